// File: rtl/hapc_pkg.sv
// shared constants for the humid air property calculator
package hapc_pkg;

    localparam logic signed [14:0] T_MIN = -15'sd12800;
    localparam logic signed [14:0] T_MAX = 15'sd15360;
    localparam logic [13:0] RH_MAX = 14'd10000;

    localparam logic [20:0] P_MAX = 21'd1310720;
    localparam logic [22:0] Q_MAX = 23'd4194304;
    localparam logic [18:0] CP_MIN = 19'd257190;
    localparam logic [18:0] CP_MAX = 19'd286000;
    localparam logic [23:0] SLOPE_MAX = 24'd16777215;

    // ln(2) in q24 and its reciprocal scaled by 2^32
    localparam int LN2_Q24 = 11629080;
    localparam int LN2_RECIP = 369;
    // bias that makes the exponent argument non-negative: 7 * ln(2)
    localparam int EXP_BIAS = 7 * LN2_Q24;
    // final shift is EXP_NORM minus the biased integer part
    localparam int EXP_NORM = 13;
    localparam int EXP_TERMS = 12;
    localparam int EXP_LAT = 2 + 3 * EXP_TERMS + 1;

    // stages of the divider by a constant
    localparam int CDIV_LAT = 3;

    // floor((2^32 - 1) / k) for k = 1 .. 12
    localparam logic [31:0] EXP_RECIP [EXP_TERMS] = '{
        32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
        32'd858993459,  32'd715827882,  32'd613566756,  32'd536870911,
        32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941
    };

endpackage

// File: rtl/hapc_delay.sv
// delay line for side data that travels alongside the pipeline
module hapc_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

// File: rtl/hapc_div.sv
// pipelined dividers: restoring with one quotient bit per stage, and by a constant
module hapc_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int TW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [NW-1:0] rem_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [NW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [QW-1:0] q_in;
        logic [TW-1:0] sh;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign r_in = rem_reg[i-1];
            assign d_in = den_reg[i-1];
            assign q_in = quo_reg[i-1];
        end

        assign sh = TW'(d_in) << (QW - 1 - i);
        assign ge = TW'(r_in) >= sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= q_in | (ge ? (QW'(1) << (QW - 1 - i)) : '0);
            end
        end

        if (i < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? NW'(TW'(r_in) - sh) : r_in;
                    den_reg[i] <= d_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

module hapc_cdiv import hapc_pkg::*; #(
    parameter int NW  = 32,
    parameter int QW  = 16,
    parameter int DIV = 10
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    output logic [QW-1:0] quo
);

    localparam int DW = $clog2(DIV + 1);
    localparam int SH = (NW > 32) ? NW - 32 : 0;
    localparam int PS = 31 + DW - SH;
    localparam logic [31:0] RCP = 32'((64'd1 << (31 + DW)) / 64'(DIV));

    logic [63:0]   prod;
    logic [QW-1:0] qe_reg;
    logic [NW-1:0] num_reg;
    logic [QW-1:0] qe2_reg;
    logic [NW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;

    // reciprocal estimate from the top 32 bits is low by at most one
    assign prod = 64'(num[NW-1:SH]) * 64'(RCP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qe_reg  <= prod[PS +: QW];
            num_reg <= num;
            qe2_reg <= qe_reg;
            rem_reg <= num_reg - NW'(qe_reg) * NW'(DIV);
            quo_reg <= qe2_reg + QW'(rem_reg >= NW'(DIV));
        end
    end

    assign quo = quo_reg;

endmodule

// File: rtl/hapc_exp.sv
// pipelined q24 exponential: range reduction by ln2 and a taylor series
module hapc_exp import hapc_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic signed [27:0] x,
    output logic [29:0]        e
);

    localparam int NT = EXP_TERMS;

    logic [27:0] u;
    logic [36:0] u_prod;
    logic [27:0] u_reg;
    logic [3:0]  qe_reg;
    logic [27:0] rem;
    logic        rem_ge;
    logic [3:0]  m_reg;
    logic [23:0] r_reg;

    logic [29:0] p1_reg [NT];
    logic [29:0] r1_reg [NT];
    logic [30:0] s1_reg [NT];
    logic [3:0]  m1_reg [NT];
    logic [29:0] qe2_reg [NT];
    logic [29:0] p2_reg [NT];
    logic [29:0] r2_reg [NT];
    logic [30:0] s2_reg [NT];
    logic [3:0]  m2_reg [NT];
    logic [30:0] s3_reg [NT];
    logic [3:0]  m3_reg [NT];
    logic [29:0] r3_reg [NT-1];
    logic [30:0] t3_reg [NT-1];

    logic [3:0]  shift;
    logic [29:0] e_reg;

    // biased argument and integer part estimate
    assign u      = 28'(29'(x) + 29'(EXP_BIAS));
    assign u_prod = 37'(u) * 37'(LN2_RECIP);

    assign rem    = u_reg - 28'(qe_reg) * 28'(LN2_Q24);
    assign rem_ge = rem >= 28'(LN2_Q24);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg  <= u;
            qe_reg <= u_prod[35:32];
            m_reg  <= qe_reg + 4'(rem_ge);
            r_reg  <= rem_ge ? 24'(rem - 28'(LN2_Q24)) : rem[23:0];
        end
    end

    for (genvar k = 0; k < NT; k++)
    begin : g_term
        logic [30:0] t_in;
        logic [30:0] s_in;
        logic [29:0] r_in;
        logic [3:0]  m_in;
        logic [60:0] prod1;
        logic [61:0] prod2;
        logic [33:0] back;
        logic [29:0] rr;
        logic        bump;
        logic [30:0] t_new;

        if (k == 0)
        begin : g_first
            assign t_in = 31'(1) << 30;
            assign s_in = 31'(1) << 30;
            assign r_in = {r_reg, 6'd0};
            assign m_in = m_reg;
        end
        else
        begin : g_next
            assign t_in = t3_reg[k-1];
            assign s_in = s3_reg[k-1];
            assign r_in = r3_reg[k-1];
            assign m_in = m3_reg[k-1];
        end

        assign prod1 = 61'(t_in) * 61'(r_in);
        // divide by k+1 through the reciprocal, then one correction
        assign prod2 = 62'(p1_reg[k]) * 62'(EXP_RECIP[k]);
        assign back  = 34'(qe2_reg[k]) * 34'(k + 1);
        assign rr    = 30'(34'(p2_reg[k]) - back);
        assign bump  = rr >= 30'(k + 1);
        assign t_new = 31'(qe2_reg[k]) + 31'(bump);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p1_reg[k]  <= prod1[59:30];
                r1_reg[k]  <= r_in;
                s1_reg[k]  <= s_in;
                m1_reg[k]  <= m_in;
                qe2_reg[k] <= prod2[61:32];
                p2_reg[k]  <= p1_reg[k];
                r2_reg[k]  <= r1_reg[k];
                s2_reg[k]  <= s1_reg[k];
                m2_reg[k]  <= m1_reg[k];
                s3_reg[k]  <= s2_reg[k] + t_new;
                m3_reg[k]  <= m2_reg[k];
            end
        end

        if (k < NT - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r3_reg[k] <= r2_reg[k];
                    t3_reg[k] <= t_new;
                end
            end
        end
    end

    assign shift = 4'(EXP_NORM) - m3_reg[NT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= 30'(s3_reg[NT-1] >> shift);
        end
    end

    assign e = e_reg;

endmodule

// File: rtl/humid_air_property_calc.sv
// top level of the humid air property calculator
//
// input channel: temperature (signed, 1/256 degC) and rel_humidity
// (0.01 percent) with valid / stall; a request is taken on a clock edge
// with valid high and stall low. out of range inputs are saturated.
// output channel: six property fields with result_valid / result_stall.
// every request gives exactly one result.
// there are 106 register stages, most of them in the bit-per-stage
// dividers for the exponent arguments and specific humidity and in the
// 39-stage exponential; one request is accepted every cycle while
// stall is low.
// the whole pipeline advances together: when a finished result is held
// by result_stall, stall rises and every stage keeps its contents, so
// nothing is lost or repeated. bubbles travel as cleared valid bits.
// reset (rst_n low) clears all valid bits; payload registers are not
// reset and the block is ready on the first cycle after reset.
module humid_air_property_calc import hapc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic signed [14:0] temperature,
    input  logic [13:0]        rel_humidity,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [20:0]        sat_vapor_pressure,
    output logic [20:0]        actual_vapor_pressure,
    output logic [20:0]        vapor_pressure_deficit,
    output logic [22:0]        specific_humidity,
    output logic [18:0]        heat_capacity_air,
    output logic [23:0]        saturation_slope
);

    localparam int X_QW  = 27;
    localparam int ES_QW = 29;
    localparam int Q_QW  = 23;
    localparam int CP_QW = 19;
    localparam int SL_QW = 25;

    // stage index at which each value sits in its register
    localparam int T_X  = 1 + X_QW;
    localparam int T_E  = T_X + 1 + EXP_LAT;
    localparam int T_ES = T_E + 1 + CDIV_LAT;
    localparam int T_EA = T_ES + 1 + CDIV_LAT;
    localparam int T_Q  = T_EA + 1 + Q_QW + 1;
    localparam int T_CP = T_Q + 1 + CDIV_LAT;
    localparam int T_SL = T_E + 2 + SL_QW;
    localparam int LAT  = T_CP + 1;

    logic            en;
    logic [LAT-1:0]  vld_reg;
    logic [LAT-1:0]  vld_next;

    // input stage
    logic signed [14:0] t_c;
    logic [13:0]        abs_t;
    logic [13:0]        rh_c;
    logic signed [21:0] d1_s;
    logic signed [24:0] d2x_s;
    logic               sgn_reg;
    logic [19:0]        d1_reg;
    logic [22:0]        d2x_reg;
    logic [45:0]        n1_reg;
    logic [48:0]        n2_reg;
    logic [13:0]        rh_reg;

    logic [26:0]        x1_q;
    logic [26:0]        x2_q;
    logic               sgn_d;
    logic signed [27:0] x1_reg;
    logic signed [27:0] x2_reg;
    logic [29:0]        e1;
    logic [29:0]        e2;

    logic [45:0]        es_num_reg;
    logic [28:0]        es_q;
    logic [13:0]        rh_d;
    logic [42:0]        ea_num_reg;
    logic [28:0]        ea_q;

    logic [40:0]        q_den;
    logic [40:0]        q_den_reg;
    logic [61:0]        q_num_reg;
    logic [22:0]        q_q;
    logic [22:0]        q_c_reg;
    logic [30:0]        cp_inner;
    logic [47:0]        cp_a;
    logic [31:0]        cp_num_reg;
    logic [18:0]        cp_q;

    logic [19:0]        d1_d;
    logic [47:0]        sl_p_reg;
    logic [39:0]        d2_reg;
    logic [63:0]        sl_num_reg;
    logic [39:0]        sl_den_reg;
    logic [24:0]        sl_q;

    logic [28:0]        es_d;
    logic [28:0]        ea_d;
    logic [22:0]        q_d;
    logic [24:0]        sl_d;

    logic [20:0]        sat_reg;
    logic [20:0]        act_reg;
    logic [20:0]        vpd_reg;
    logic [22:0]        spec_reg;
    logic [18:0]        cp_reg;
    logic [23:0]        slope_reg;

    function automatic logic [20:0] to_p16(input logic [28:0] v);
        logic [21:0] r;
        r = 22'((30'(v) + 30'd128) >> 8);
        return (r > 22'(P_MAX)) ? P_MAX : r[20:0];
    endfunction

    assign en       = !(vld_reg[LAT-1] && result_stall);
    assign stall    = !en;
    assign vld_next = {vld_reg[LAT-2:0], valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        t_c = temperature;
        if (temperature < T_MIN)
        begin
            t_c = T_MIN;
        end
        else if (temperature > T_MAX)
        begin
            t_c = T_MAX;
        end
        rh_c  = (rel_humidity > RH_MAX) ? RH_MAX : rel_humidity;
        abs_t = t_c[14] ? 14'(-t_c) : 14'(t_c);
        d1_s  = 22'sd607488 + 22'(t_c) * 22'sd10;
        d2x_s = 25'sd6074880 + 25'(t_c) * 25'sd100;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_reg <= t_c[14];
            d1_reg  <= d1_s[19:0];
            d2x_reg <= d2x_s[22:0];
            n1_reg  <= (46'(abs_t) * 46'd173) << 24;
            n2_reg  <= (49'(abs_t) * 49'd1727) << 24;
            rh_reg  <= rh_c;
        end
    end

    // exponent arguments, divided on magnitudes and signed afterwards
    hapc_div #(.NW(46), .DW(20), .QW(X_QW)) u_div_x1 (
        .clk(clk), .en(en), .num(n1_reg), .den(d1_reg), .quo(x1_q)
    );

    hapc_div #(.NW(49), .DW(23), .QW(X_QW)) u_div_x2 (
        .clk(clk), .en(en), .num(n2_reg), .den(d2x_reg), .quo(x2_q)
    );

    hapc_delay #(.W(1), .N(T_X - 1)) u_dly_sgn (
        .clk(clk), .en(en), .d(sgn_reg), .q(sgn_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= sgn_d ? -$signed({1'b0, x1_q}) : $signed({1'b0, x1_q});
            x2_reg <= sgn_d ? -$signed({1'b0, x2_q}) : $signed({1'b0, x2_q});
        end
    end

    hapc_exp u_exp1 (.clk(clk), .en(en), .x(x1_reg), .e(e1));
    hapc_exp u_exp2 (.clk(clk), .en(en), .x(x2_reg), .e(e2));

    // saturation and actual vapor pressure
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            es_num_reg <= 46'(e1) * 46'd61078 + 46'd50000;
            ea_num_reg <= 43'(es_q) * 43'(rh_d) + 43'd5000;
        end
    end

    hapc_cdiv #(.NW(46), .QW(ES_QW), .DIV(100000)) u_div_es (
        .clk(clk), .en(en), .num(es_num_reg), .quo(es_q)
    );

    hapc_delay #(.W(14), .N(T_ES - 1)) u_dly_rh (
        .clk(clk), .en(en), .d(rh_reg), .q(rh_d)
    );

    hapc_cdiv #(.NW(43), .QW(ES_QW), .DIV(10000)) u_div_ea (
        .clk(clk), .en(en), .num(ea_num_reg), .quo(ea_q)
    );

    // specific humidity and heat capacity
    assign q_den    = (41'd101350 << 24) - 41'(ea_q) * 41'd378;
    assign cp_inner = 31'd1677721600 + 31'(q_c_reg) * 31'd84;
    assign cp_a     = 48'(cp_inner) * 48'd100465 + 48'd327680000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_den_reg  <= q_den;
            q_num_reg  <= ((62'(ea_q) * 62'd622) << 24) + 62'(q_den >> 1);
            q_c_reg    <= (q_q > Q_MAX) ? Q_MAX : q_q;
            cp_num_reg <= cp_a[47:16];
        end
    end

    hapc_div #(.NW(62), .DW(41), .QW(Q_QW)) u_div_q (
        .clk(clk), .en(en), .num(q_num_reg), .den(q_den_reg), .quo(q_q)
    );

    hapc_cdiv #(.NW(32), .QW(CP_QW), .DIV(10000)) u_div_cp (
        .clk(clk), .en(en), .num(cp_num_reg), .quo(cp_q)
    );

    // slope of the saturation curve
    hapc_delay #(.W(20), .N(T_E - 1)) u_dly_d1 (
        .clk(clk), .en(en), .d(d1_reg), .q(d1_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_p_reg   <= 48'(e2) * 48'd250300;
            d2_reg     <= 40'(d1_d) * 40'(d1_d);
            sl_num_reg <= {sl_p_reg, 16'd0} + 64'(d2_reg >> 1);
            sl_den_reg <= d2_reg;
        end
    end

    hapc_div #(.NW(64), .DW(40), .QW(SL_QW)) u_div_sl (
        .clk(clk), .en(en), .num(sl_num_reg), .den(sl_den_reg), .quo(sl_q)
    );

    // line everything up with the heat capacity result
    hapc_delay #(.W(29), .N(T_CP - T_ES)) u_dly_es (
        .clk(clk), .en(en), .d(es_q), .q(es_d)
    );

    hapc_delay #(.W(29), .N(T_CP - T_EA)) u_dly_ea (
        .clk(clk), .en(en), .d(ea_q), .q(ea_d)
    );

    hapc_delay #(.W(23), .N(T_CP - T_Q)) u_dly_q (
        .clk(clk), .en(en), .d(q_c_reg), .q(q_d)
    );

    hapc_delay #(.W(25), .N(T_CP - T_SL)) u_dly_sl (
        .clk(clk), .en(en), .d(sl_q), .q(sl_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg   <= to_p16(es_d);
            act_reg   <= to_p16(ea_d);
            vpd_reg   <= to_p16(es_d - ea_d);
            spec_reg  <= q_d;
            if (cp_q < CP_MIN)
            begin
                cp_reg <= CP_MIN;
            end
            else if (cp_q > CP_MAX)
            begin
                cp_reg <= CP_MAX;
            end
            else
            begin
                cp_reg <= cp_q;
            end
            slope_reg <= (sl_d > 25'(SLOPE_MAX)) ? SLOPE_MAX : sl_d[23:0];
        end
    end

    assign result_valid           = vld_reg[LAT-1];
    assign sat_vapor_pressure     = sat_reg;
    assign actual_vapor_pressure  = act_reg;
    assign vapor_pressure_deficit = vpd_reg;
    assign specific_humidity      = spec_reg;
    assign heat_capacity_air      = cp_reg;
    assign saturation_slope       = slope_reg;

endmodule
